// ===== rtl/core/rxrb_pkg.sv =====
package rxrb_pkg;

	// Ring geometry
	localparam int DEPTH = 32;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	// Register reset values and register indexes
	localparam logic [7:0] DROP_CHAR_RST     = 8'd10;
	localparam logic [7:0] LINE_END_CHAR_RST = 8'd13;
	localparam logic       REG_DROP_CHAR     = 1'b0;
	localparam logic       REG_LINE_END_CHAR = 1'b1;

	// Operation codes
	typedef enum logic [1:0] {
		FUNC_PUSH  = 2'd0,
		FUNC_READ  = 2'd1,
		FUNC_CLEAR = 2'd2,
		FUNC_NOP   = 2'd3
	} func_t;

	// Request from the pointer logic to the byte store
	typedef struct packed {
		logic             we;
		logic [PTR_W-1:0] waddr;
		logic [7:0]       wdata;
		logic             re;
		logic [PTR_W-1:0] raddr;
	} store_req_t;

	// Next ring index with wrap at the last entry
	function automatic logic [PTR_W-1:0] next_index(input logic [PTR_W-1:0] p);
		return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
	endfunction

endpackage

// ===== rtl/core/rxrb_store.sv =====
module rxrb_store (
	input  logic                    clk,
	input  rxrb_pkg::store_req_t    req,
	output logic [7:0]              rd_data_s1
);
	import rxrb_pkg::*;

	logic [7:0] mem [DEPTH];

	// One write port
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (req.re) begin
			rd_data_s1 <= mem[req.raddr];
		end
	end

endmodule

// ===== rtl/core/rxrb_ctrl.sv =====
module rxrb_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    accept,
	input  logic [1:0]              func,
	input  logic [7:0]              rx_byte,
	input  logic                    cfg_we,
	input  logic                    cfg_index,
	input  logic [7:0]              cfg_wdata,
	output rxrb_pkg::store_req_t    req,
	output logic                    done_s1,
	output logic                    read_valid_s1,
	output logic                    line_end_s1,
	output logic                    overwrote_s1
);
	import rxrb_pkg::*;

	logic [7:0]       drop_char_q;
	logic [7:0]       line_end_char_q;
	logic [PTR_W-1:0] rptr_q;
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] wptr_nxt;
	logic [PTR_W-1:0] rptr_inc;
	logic             is_push;
	logic             is_read;
	logic             is_clear;
	logic             not_empty;
	logic             full_hit;

	// Operation decode
	always_comb begin
		is_push  = 1'b0;
		is_read  = 1'b0;
		is_clear = 1'b0;
		unique case (func_t'(func))
			FUNC_PUSH:  is_push  = accept && (rx_byte != drop_char_q);
			FUNC_READ:  is_read  = accept;
			FUNC_CLEAR: is_clear = accept;
			default:    ;
		endcase
	end

	assign not_empty = (rptr_q != wptr_q);
	assign wptr_nxt  = next_index(wptr_q);
	assign rptr_inc  = next_index(rptr_q);
	assign full_hit  = (wptr_nxt == rptr_q);

	// Store access
	always_comb begin
		req.we    = is_push;
		req.waddr = wptr_q;
		req.wdata = rx_byte;
		req.re    = is_read && not_empty;
		req.raddr = rptr_q;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_char_q     <= DROP_CHAR_RST;
			line_end_char_q <= LINE_END_CHAR_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_DROP_CHAR) begin
				drop_char_q <= cfg_wdata;
			end
			if (cfg_index == REG_LINE_END_CHAR) begin
				line_end_char_q <= cfg_wdata;
			end
		end
	end

	// Ring pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rptr_q <= '0;
			wptr_q <= '0;
		end else begin
			if (is_push) begin
				wptr_q <= wptr_nxt;
				if (full_hit) begin
					rptr_q <= rptr_inc;
				end
			end else if (is_read && not_empty) begin
				rptr_q <= rptr_inc;
			end else if (is_clear) begin
				rptr_q <= wptr_q;
			end
		end
	end

	// Result flags, registered in the cycle after the item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1       <= 1'b0;
			read_valid_s1 <= 1'b0;
			line_end_s1   <= 1'b0;
			overwrote_s1  <= 1'b0;
		end else begin
			done_s1       <= accept;
			read_valid_s1 <= is_read && not_empty;
			line_end_s1   <= is_push && (rx_byte == line_end_char_q);
			overwrote_s1  <= is_push && full_hit;
		end
	end

	// Checks
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done_s1)
		else $error("result strobe missing after accepted item");

	a_flags_need_done: assert property (@(posedge clk) disable iff (!arst_n)
		(read_valid_s1 || line_end_s1 || overwrote_s1) |-> done_s1)
		else $error("result flag without strobe");

	a_overwrite_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		overwrote_s1 |-> (!read_valid_s1 && rptr_q == next_index(wptr_q)))
		else $error("pointers inconsistent after overwrite");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		is_clear |=> (rptr_q == wptr_q))
		else $error("ring not empty after clear");

endmodule

// ===== rtl/core/uart_rx_line_ring_buffer.sv =====
// Channel  Handshake          Payload
// input    start / busy       func, rx_byte
// result   done (strobe)      read_byte, read_valid, line_end, overwrote
// config   cfg_we             cfg_index, cfg_wdata
//
// An item is taken at any edge with start high; busy is always low, so one
// push, read or clear enters every cycle. Its result shows on the result ports
// for one cycle, in the cycle after the item, since the store's read port is
// registered. Reset is asynchronous, active low, and leaves the ring
// empty; stored bytes are not cleared. The receiver cannot stall.
module uart_rx_line_ring_buffer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] func,
	input  logic [7:0] rx_byte,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_wdata,
	output logic       done,
	output logic [7:0] read_byte,
	output logic       read_valid,
	output logic       line_end,
	output logic       overwrote
);
	import rxrb_pkg::*;

	store_req_t req;
	logic [7:0] rd_data_s1;
	logic       accept;
	logic       read_valid_s1;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	rxrb_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.func          (func),
		.rx_byte       (rx_byte),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.req           (req),
		.done_s1       (done),
		.read_valid_s1 (read_valid_s1),
		.line_end_s1   (line_end),
		.overwrote_s1  (overwrote)
	);

	rxrb_store u_store (
		.clk        (clk),
		.req        (req),
		.rd_data_s1 (rd_data_s1)
	);

	// Popped byte, zero when no byte came back
	assign read_valid = read_valid_s1;
	assign read_byte  = read_valid_s1 ? rd_data_s1 : 8'd0;

endmodule

// ===== tb/sv/uart_rx_line_ring_buffer_tb.sv =====
`timescale 1ns / 1ps

module uart_rx_line_ring_buffer_tb;
	import rxrb_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int REPORT_MAX  = 10;
	localparam int RANDOM_ITEMS = 1800;

	// One result of a push, read or clear
	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic       line_end;
		logic       over;
	} op_result_t;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [1:0] func;
	logic [7:0] rx_byte;
	logic       cfg_we;
	logic       cfg_index;
	logic [7:0] cfg_wdata;
	logic       done;
	logic [7:0] read_byte;
	logic       read_valid;
	logic       line_end;
	logic       overwrote;

	uart_rx_line_ring_buffer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.rx_byte    (rx_byte),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.done       (done),
		.read_byte  (read_byte),
		.read_valid (read_valid),
		.line_end   (line_end),
		.overwrote  (overwrote)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Shadow of the ring and the character registers
	logic [7:0]       ring_mem [DEPTH];
	logic [PTR_W-1:0] head_ptr;
	logic [PTR_W-1:0] tail_ptr;
	logic [7:0]       cfg_drop;
	logic [7:0]       cfg_line_end;

	op_result_t op_results_q [$];

	int mismatch_count;
	int idle_cycles;
	int items_sent;
	int gap_pct;
	int n_stored, n_popped, n_empty, n_clears, n_over;
	int n_lines, n_dropped, n_nops, n_reg_writes;

	function automatic logic [PTR_W-1:0] ring_step(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	// Predict one item and advance the shadow ring
	function automatic op_result_t ring_predict(input func_t f, input logic [7:0] b);
		op_result_t r;
		r = '0;
		case (f)
			FUNC_PUSH: begin
				if (b == cfg_drop) begin
					n_dropped++;
				end else begin
					ring_mem[tail_ptr] = b;
					tail_ptr = ring_step(tail_ptr);
					if (tail_ptr == head_ptr) begin
						head_ptr = ring_step(head_ptr);
						r.over = 1'b1;
						n_over++;
					end
					r.line_end = (b == cfg_line_end);
					n_stored++;
					if (r.line_end) n_lines++;
				end
			end
			FUNC_READ: begin
				if (head_ptr != tail_ptr) begin
					r.data = ring_mem[head_ptr];
					r.valid = 1'b1;
					head_ptr = ring_step(head_ptr);
					n_popped++;
				end else begin
					n_empty++;
				end
			end
			FUNC_CLEAR: begin
				head_ptr = tail_ptr;
				n_clears++;
			end
			default: n_nops++;
		endcase
		return r;
	endfunction

	task automatic note_failure(input string what, input op_result_t want,
		input op_result_t got);
		mismatch_count++;
		if (mismatch_count <= REPORT_MAX)
			$display({"%0t %s: expected byte %02h valid %b line_end %b overwrote %b,",
				" got byte %02h valid %b line_end %b overwrote %b"},
				$time, what, want.data, want.valid, want.line_end, want.over,
				got.data, got.valid, got.line_end, got.over);
	endtask

	// Sample items, register writes and results; watchdog
	always @(posedge clk) begin
		op_result_t got;
		op_result_t want;
		logic       took;
		if (arst_n) begin
			took = start && !busy;
			if (done) begin
				got = {read_byte, read_valid, line_end, overwrote};
				if (op_results_q.size() == 0) begin
					note_failure("result with no item waiting", '0, got);
				end else begin
					want = op_results_q.pop_front();
					if (got.data !== want.data || got.valid !== want.valid ||
					    got.line_end !== want.line_end || got.over !== want.over)
						note_failure("result mismatch", want, got);
				end
			end
			if (cfg_we) begin
				n_reg_writes++;
				case (cfg_index)
					REG_DROP_CHAR:     cfg_drop = cfg_wdata;
					REG_LINE_END_CHAR: cfg_line_end = cfg_wdata;
				endcase
			end
			if (took)
				op_results_q.push_back(ring_predict(func_t'(func), rx_byte));
			if (took || done)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout: no item or result for %0d cycles", STALL_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// Drive one item at the falling edge; returns at the edge that takes it
	task automatic send_item(input func_t f, input logic [7:0] b);
		@(negedge clk);
		while ($urandom_range(99) < gap_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		func = f;
		rx_byte = b;
		while (busy) @(negedge clk);
		@(posedge clk);
		items_sent++;
	endtask

	// Stop sending and let every outstanding result come back
	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (op_results_q.size() != 0) @(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Registers change only with the ring idle
	task automatic set_chars(input logic [7:0] drop_val, input logic [7:0] eol_val);
		drain();
		write_reg(REG_DROP_CHAR, drop_val);
		write_reg(REG_LINE_END_CHAR, eol_val);
	endtask

	// Mostly random bytes, with the two special characters mixed in
	function automatic logic [7:0] pick_byte();
		int roll;
		roll = $urandom_range(99);
		if (roll < 8) return cfg_drop;
		if (roll < 18) return cfg_line_end;
		return 8'($urandom);
	endfunction

	// Extremes, every operation, drop and line end, empty read, clear
	task automatic test_basic_ops();
		gap_pct = 0;
		send_item(FUNC_READ, 8'h00);
		send_item(FUNC_PUSH, 8'h00);
		send_item(FUNC_PUSH, 8'hFF);
		send_item(FUNC_PUSH, 8'hAA);
		send_item(FUNC_PUSH, 8'h55);
		send_item(FUNC_PUSH, DROP_CHAR_RST);
		send_item(FUNC_PUSH, LINE_END_CHAR_RST);
		send_item(FUNC_NOP, 8'hFF);
		repeat (6) send_item(FUNC_READ, 8'hFF);
		send_item(FUNC_PUSH, 8'h12);
		send_item(FUNC_PUSH, 8'h34);
		send_item(FUNC_CLEAR, 8'h00);
		send_item(FUNC_READ, 8'h00);
		send_item(FUNC_PUSH, 8'h56);
		send_item(FUNC_READ, 8'h00);
		send_item(FUNC_READ, 8'h00);
		drain();
	endtask

	// Fill past capacity so the oldest bytes are overwritten, then empty it
	task automatic test_ring_full();
		gap_pct = 0;
		repeat (DEPTH + 8) send_item(FUNC_PUSH, pick_byte());
		repeat (DEPTH + 1) send_item(FUNC_READ, 8'($urandom));
		drain();
	endtask

	// Register extremes, and drop and line end set to the same value
	task automatic test_char_registers();
		gap_pct = 0;
		set_chars(8'h00, 8'hFF);
		send_item(FUNC_PUSH, 8'h00);
		send_item(FUNC_PUSH, 8'hFF);
		send_item(FUNC_PUSH, DROP_CHAR_RST);
		repeat (3) send_item(FUNC_READ, 8'h00);
		set_chars(8'h41, 8'h41);
		send_item(FUNC_PUSH, 8'h41);
		send_item(FUNC_PUSH, LINE_END_CHAR_RST);
		repeat (2) send_item(FUNC_READ, 8'h00);
		set_chars(8'hFF, 8'h00);
		send_item(FUNC_PUSH, 8'hFF);
		send_item(FUNC_PUSH, 8'h00);
		repeat (2) send_item(FUNC_READ, 8'h00);
		drain();
	endtask

	// Bursts of pushes and reads with random content, plus noise
	task automatic test_random_traffic();
		int phase_pct [4] = '{0, 50, 0, 16};
		int phase_end;
		int burst;
		int reads;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: set_chars(DROP_CHAR_RST, LINE_END_CHAR_RST);
				1: set_chars(8'h00, 8'hFF);
				2: set_chars(8'h5A, 8'h5A);
				default: set_chars(8'($urandom), 8'($urandom));
			endcase
			gap_pct = phase_pct[ph];
			phase_end = items_sent + RANDOM_ITEMS / 4;
			while (items_sent < phase_end) begin
				if ($urandom_range(99) < 70) begin
					burst = ($urandom_range(9) == 0) ? $urandom_range(DEPTH - 4, DEPTH + 12)
						: $urandom_range(1, 12);
					repeat (burst) send_item(FUNC_PUSH, pick_byte());
					reads = $urandom_range(1, burst + 2);
					repeat (reads) send_item(FUNC_READ, 8'($urandom));
					if ($urandom_range(9) == 0) send_item(FUNC_CLEAR, 8'($urandom));
				end else begin
					repeat ($urandom_range(1, 8))
						send_item(func_t'($urandom_range(3)), 8'($urandom));
				end
			end
		end
		drain();
	endtask

	initial begin
		start = 1'b0;
		func = FUNC_PUSH;
		rx_byte = 8'h00;
		cfg_we = 1'b0;
		cfg_index = REG_DROP_CHAR;
		cfg_wdata = 8'h00;
		arst_n = 1'b0;
		head_ptr = '0;
		tail_ptr = '0;
		cfg_drop = DROP_CHAR_RST;
		cfg_line_end = LINE_END_CHAR_RST;
		gap_pct = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		test_basic_ops();
		test_ring_full();
		test_char_registers();
		test_random_traffic();

		// anything still waiting is a missing result
		mismatch_count += op_results_q.size();
		$display("%0d items: %0d bytes stored, %0d popped, %0d empty reads, %0d clears",
			items_sent, n_stored, n_popped, n_empty, n_clears);
		$display("%0d no-ops, %0d overwrites, %0d line ends, %0d dropped, %0d reg writes",
			n_nops, n_over, n_lines, n_dropped, n_reg_writes);
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d failures", mismatch_count);
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
